FILE: design/fnm_pkg.sv
// Shared types and constants for the facet normal and measure unit.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package fnm_pkg;

    localparam logic [1:0] KIND_TRI_EDGE  = 2'd0;
    localparam logic [1:0] KIND_QUAD_EDGE = 2'd1;
    localparam logic [1:0] KIND_TRI_FACE  = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_EDGE = 2'd1;
    localparam logic [1:0] STATUS_DEGEN    = 2'd2;

    // Square root radicand, root and partial remainder widths.
    localparam int RAD_W      = 132;
    localparam int ROOT_W     = 66;
    localparam int REM_W      = 68;
    localparam int SQRT_CELLS = 66;

    // Edge length divisor, division remainder and quotient widths.
    localparam int DIV_W     = 49;
    localparam int DR_W      = 50;
    localparam int Q_W       = 33;
    localparam int DIV_CELLS = 33;

    typedef struct packed {
        logic [1:0]         edge_index;
        logic signed [31:0] x0;
        logic signed [31:0] x1;
        logic signed [31:0] x2;
        logic signed [31:0] x3;
        logic signed [31:0] y0;
        logic signed [31:0] y1;
        logic signed [31:0] y2;
        logic signed [31:0] y3;
        logic signed [31:0] z0;
        logic signed [31:0] z1;
        logic signed [31:0] z2;
    } in_t;

    typedef struct packed {
        logic signed [63:0] nx;
        logic signed [63:0] ny;
        logic signed [63:0] nz;
        logic [62:0]        surface_measure;
        logic [1:0]         status;
    } out_t;

    // Per-item side information that rides along the whole pipeline.
    typedef struct packed {
        logic        is_face;
        logic [1:0]  status;
        logic        neg0;
        logic        neg1;
        logic [31:0] mag0;
        logic [31:0] mag1;
        logic [63:0] fnx;
        logic [63:0] fny;
        logic [63:0] fnz;
        logic [62:0] surf;
    } fnm_meta_t;

    typedef struct packed {
        fnm_meta_t          meta;
        logic [RAD_W-1:0]   rad;
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
    } fnm_sq_t;

    typedef struct packed {
        fnm_meta_t         meta;
        logic [DIV_W-1:0]  d;
        logic [DR_W-1:0]   r0;
        logic [DR_W-1:0]   r1;
        logic [Q_W-1:0]    q0;
        logic [Q_W-1:0]    q1;
    } fnm_dv_t;

endpackage

`default_nettype wire

FILE: design/fnm_front.sv
// Front end of the facet unit: edge or face differences, products, cross
// terms and the square root radicand. Depends on fnm_pkg.
`default_nettype none

module fnm_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            adv,
    input  wire logic            in_valid,
    input  wire fnm_pkg::in_t    in_data,
    input  wire logic [1:0]      kind,
    output logic                 out_valid,
    output fnm_pkg::fnm_sq_t     out_data
);

    localparam int RAD_W_L = fnm_pkg::RAD_W;

    function automatic logic [31:0] pick(input logic [1:0] i, input logic [31:0] a,
                                         input logic [31:0] b, input logic [31:0] c,
                                         input logic [31:0] d);
        logic [31:0] r;
        case (i)
            2'd0:    r = a;
            2'd1:    r = b;
            2'd2:    r = c;
            default: r = d;
        endcase
        return r;
    endfunction

    function automatic logic [32:0] diff(input logic [31:0] a, input logic [31:0] b);
        return {a[31], a} - {b[31], b};
    endfunction

    function automatic logic [31:0] absv(input logic [32:0] v);
        logic [32:0] t;
        t = v[32] ? (~v + 33'd1) : v;
        return t[31:0];
    endfunction

    function automatic logic [63:0] sat64(input logic neg, input logic [64:0] m);
        logic [63:0] r;
        if (!neg)
        begin
            r = (m[64] || m[63]) ? 64'h7FFF_FFFF_FFFF_FFFF : m[63:0];
        end
        else
        begin
            r = (m[64] || (m[63] && (m[62:0] != 63'd0))) ? 64'h8000_0000_0000_0000
                                                          : 64'd0 - m[63:0];
        end
        return r;
    endfunction

    // Stage 1: differences and multiplier operands.
    logic [1:0]  ia, ib;
    logic [32:0] n0, n1, ux, uy, uz, vx, vy, vz;
    logic        is_face, bad_edge;
    logic [31:0] opa_next [6];
    logic [31:0] opb_next [6];
    logic [5:0]  psg_next;
    fnm_pkg::fnm_meta_t m1_next;

    logic               s1_valid_reg;
    logic [31:0]        s1_opa_reg [6];
    logic [31:0]        s1_opb_reg [6];
    logic [5:0]         s1_psg_reg;
    fnm_pkg::fnm_meta_t s1_meta_reg;

    always_comb
    begin
        ia = in_data.edge_index;
        ib = (kind == fnm_pkg::KIND_TRI_EDGE && ia == 2'd2) ? 2'd0 : ia + 2'd1;
        n0 = diff(pick(ib, in_data.y0, in_data.y1, in_data.y2, in_data.y3),
                  pick(ia, in_data.y0, in_data.y1, in_data.y2, in_data.y3));
        n1 = diff(pick(ia, in_data.x0, in_data.x1, in_data.x2, in_data.x3),
                  pick(ib, in_data.x0, in_data.x1, in_data.x2, in_data.x3));
        ux = diff(in_data.x0, in_data.x1);
        uy = diff(in_data.y0, in_data.y1);
        uz = diff(in_data.z0, in_data.z1);
        vx = diff(in_data.x0, in_data.x2);
        vy = diff(in_data.y0, in_data.y2);
        vz = diff(in_data.z0, in_data.z2);
        is_face  = kind[1];
        bad_edge = (kind == fnm_pkg::KIND_TRI_EDGE) && (ia == 2'd3);

        if (is_face)
        begin
            // Component pairs: (uy vz - vy uz), (vx uz - ux vz), (ux vy - vx uy).
            opa_next[0] = absv(uy); opb_next[0] = absv(vz); psg_next[0] = uy[32] ^ vz[32];
            opa_next[1] = absv(vy); opb_next[1] = absv(uz); psg_next[1] = vy[32] ^ uz[32];
            opa_next[2] = absv(vx); opb_next[2] = absv(uz); psg_next[2] = vx[32] ^ uz[32];
            opa_next[3] = absv(ux); opb_next[3] = absv(vz); psg_next[3] = ux[32] ^ vz[32];
            opa_next[4] = absv(ux); opb_next[4] = absv(vy); psg_next[4] = ux[32] ^ vy[32];
            opa_next[5] = absv(vx); opb_next[5] = absv(uy); psg_next[5] = vx[32] ^ uy[32];
        end
        else
        begin
            opa_next[0] = absv(n0); opb_next[0] = absv(n0); psg_next[0] = 1'b0;
            opa_next[1] = absv(n1); opb_next[1] = absv(n1); psg_next[1] = 1'b0;
            opa_next[2] = '0;       opb_next[2] = '0;       psg_next[2] = 1'b0;
            opa_next[3] = '0;       opb_next[3] = '0;       psg_next[3] = 1'b0;
            opa_next[4] = '0;       opb_next[4] = '0;       psg_next[4] = 1'b0;
            opa_next[5] = '0;       opb_next[5] = '0;       psg_next[5] = 1'b0;
        end

        m1_next         = '0;
        m1_next.is_face = is_face;
        m1_next.neg0    = n0[32];
        m1_next.neg1    = n1[32];
        m1_next.mag0    = absv(n0);
        m1_next.mag1    = absv(n1);
        if (bad_edge)
        begin
            m1_next.status = fnm_pkg::STATUS_BAD_EDGE;
        end
        else if (!is_face && n0 == 33'd0 && n1 == 33'd0)
        begin
            m1_next.status = fnm_pkg::STATUS_DEGEN;
        end
        else
        begin
            m1_next.status = fnm_pkg::STATUS_OK;
        end
    end

    // Stage 2: six 32x32 products.
    logic               s2_valid_reg;
    logic [63:0]        s2_prod_reg [6];
    logic [5:0]         s2_psg_reg;
    fnm_pkg::fnm_meta_t s2_meta_reg;

    // Stage 3: cross components in sign-magnitude form, or the edge square sum.
    logic [65:0] t_w [6];
    logic [65:0] c_w [3];
    logic [64:0] cmag_next [3];
    logic [2:0]  cneg_next;

    logic               s3_valid_reg;
    logic [64:0]        s3_cmag_reg [3];
    logic [2:0]         s3_cneg_reg;
    logic [64:0]        s3_esum_reg;
    fnm_pkg::fnm_meta_t s3_meta_reg;

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            t_w[k] = s2_psg_reg[k] ? 66'd0 - {2'b00, s2_prod_reg[k]} : {2'b00, s2_prod_reg[k]};
        end
        for (int i = 0; i < 3; i++)
        begin
            c_w[i]       = t_w[2 * i] - t_w[2 * i + 1];
            cneg_next[i] = c_w[i][65];
            cmag_next[i] = c_w[i][65] ? 65'(66'd0 - c_w[i]) : c_w[i][64:0];
        end
    end

    // Stage 4: split squares of the cross components, saturated normal.
    logic [32:0] hi_w [3];
    logic [31:0] lo_w [3];
    fnm_pkg::fnm_meta_t m4_next;

    logic               s4_valid_reg;
    logic [65:0]        s4_hh_reg [3];
    logic [64:0]        s4_hl_reg [3];
    logic [63:0]        s4_ll_reg [3];
    logic [RAD_W_L-1:0] s4_erad_reg;
    fnm_pkg::fnm_meta_t s4_meta_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            hi_w[i] = s3_cmag_reg[i][64:32];
            lo_w[i] = s3_cmag_reg[i][31:0];
        end
        m4_next     = s3_meta_reg;
        m4_next.fnx = sat64(s3_cneg_reg[0], s3_cmag_reg[0]);
        m4_next.fny = sat64(s3_cneg_reg[1], s3_cmag_reg[1]);
        m4_next.fnz = sat64(s3_cneg_reg[2], s3_cmag_reg[2]);
        if (s3_meta_reg.is_face && s3_cmag_reg[0] == 65'd0 && s3_cmag_reg[1] == 65'd0
            && s3_cmag_reg[2] == 65'd0)
        begin
            m4_next.status = fnm_pkg::STATUS_DEGEN;
        end
    end

    // Stage 5: per-component squares; stage 6: radicand.
    logic               s5_valid_reg;
    logic [RAD_W_L-1:0] s5_sq_reg [3];
    fnm_pkg::fnm_meta_t s5_meta_reg;
    logic [RAD_W_L-1:0] sq_w [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_w[i] = {2'd0, s4_hh_reg[i], 64'd0} + {34'd0, s4_hl_reg[i], 33'd0}
                      + {68'd0, s4_ll_reg[i]};
        end
        if (!s4_meta_reg.is_face)
        begin
            sq_w[0] = s4_erad_reg;
            sq_w[1] = '0;
            sq_w[2] = '0;
        end
    end

    logic               s6_valid_reg;
    fnm_pkg::fnm_sq_t   s6_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 6; k++)
            begin
                s1_opa_reg[k]  <= opa_next[k];
                s1_opb_reg[k]  <= opb_next[k];
                s2_prod_reg[k] <= 64'(s1_opa_reg[k]) * 64'(s1_opb_reg[k]);
            end
            s1_psg_reg  <= psg_next;
            s1_meta_reg <= m1_next;

            s2_psg_reg  <= s1_psg_reg;
            s2_meta_reg <= s1_meta_reg;

            for (int i = 0; i < 3; i++)
            begin
                s3_cmag_reg[i] <= cmag_next[i];
                s4_hh_reg[i]   <= 66'(hi_w[i]) * 66'(hi_w[i]);
                s4_hl_reg[i]   <= 65'(hi_w[i]) * 65'(lo_w[i]);
                s4_ll_reg[i]   <= 64'(lo_w[i]) * 64'(lo_w[i]);
                s5_sq_reg[i]   <= sq_w[i];
            end
            s3_cneg_reg <= cneg_next;
            s3_esum_reg <= {1'b0, s2_prod_reg[0]} + {1'b0, s2_prod_reg[1]};
            s3_meta_reg <= s2_meta_reg;

            s4_erad_reg <= {35'd0, s3_esum_reg, 32'd0};
            s4_meta_reg <= m4_next;

            s5_meta_reg <= s4_meta_reg;

            s6_data_reg.meta <= s5_meta_reg;
            s6_data_reg.rad  <= s5_sq_reg[0] + s5_sq_reg[1] + s5_sq_reg[2];
            s6_data_reg.rem  <= '0;
            s6_data_reg.root <= '0;
        end
    end

    assign out_valid = s6_valid_reg;
    assign out_data  = s6_data_reg;

endmodule

`default_nettype wire

FILE: design/fnm_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per item.
// Depends on fnm_pkg.
`default_nettype none

module fnm_sqrt_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire fnm_pkg::fnm_sq_t  in_data,
    output logic                   out_valid,
    output fnm_pkg::fnm_sq_t       out_data
);

    localparam int RW = fnm_pkg::REM_W;
    localparam int QW = fnm_pkg::ROOT_W;

    logic             valid_reg;
    fnm_pkg::fnm_sq_t data_reg;
    fnm_pkg::fnm_sq_t data_next;
    logic [RW+1:0]    rem_w;
    logic [RW+1:0]    trial_w;

    // Restoring digit recurrence: two radicand bits in, one root bit out.
    always_comb
    begin
        rem_w     = {in_data.rem, in_data.rad[fnm_pkg::RAD_W-1 -: 2]};
        trial_w   = {{(RW - QW){1'b0}}, in_data.root, 2'b01};
        data_next = in_data;
        data_next.rad = {in_data.rad[fnm_pkg::RAD_W-3:0], 2'b00};
        if (rem_w >= trial_w)
        begin
            data_next.rem  = RW'(rem_w - trial_w);
            data_next.root = {in_data.root[QW-2:0], 1'b1};
        end
        else
        begin
            data_next.rem  = rem_w[RW-1:0];
            data_next.root = {in_data.root[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

FILE: design/fnm_div_cell.sv
// One cell of the division chain: one quotient bit of each of the two
// unit normal components per item. Depends on fnm_pkg.
`default_nettype none

module fnm_div_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire fnm_pkg::fnm_dv_t  in_data,
    output logic                   out_valid,
    output fnm_pkg::fnm_dv_t       out_data
);

    localparam int RW = fnm_pkg::DR_W;
    localparam int QW = fnm_pkg::Q_W;

    logic             valid_reg;
    fnm_pkg::fnm_dv_t data_reg;
    fnm_pkg::fnm_dv_t data_next;
    logic [RW:0]      r0_w, r1_w, d_w;

    always_comb
    begin
        r0_w      = {in_data.r0, 1'b0};
        r1_w      = {in_data.r1, 1'b0};
        d_w       = {{(RW + 1 - fnm_pkg::DIV_W){1'b0}}, in_data.d};
        data_next = in_data;
        if (r0_w >= d_w)
        begin
            data_next.r0 = RW'(r0_w - d_w);
            data_next.q0 = {in_data.q0[QW-2:0], 1'b1};
        end
        else
        begin
            data_next.r0 = r0_w[RW-1:0];
            data_next.q0 = {in_data.q0[QW-2:0], 1'b0};
        end
        if (r1_w >= d_w)
        begin
            data_next.r1 = RW'(r1_w - d_w);
            data_next.q1 = {in_data.q1[QW-2:0], 1'b1};
        end
        else
        begin
            data_next.r1 = r1_w[RW-1:0];
            data_next.q1 = {in_data.q1[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

FILE: design/facet_normal_and_measure_unit.sv
// Pipeline: 6 front stages, 66 square root cells, 33 division cells and 1 output
// register lie between an accepted item and its result item.
// Throughput: one item per cycle; the whole pipeline holds while a result
// waits in the output register and is not taken.
// Reset clears all valid bits and sets the facet kind to triangle edge.
// Depends on fnm_pkg, fnm_front, fnm_sqrt_cell and fnm_div_cell.
`default_nettype none

module facet_normal_and_measure_unit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire fnm_pkg::in_t   in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output fnm_pkg::out_t       out_data,
    input  wire logic           cfg_we,
    input  wire logic [1:0]     cfg_wdata
);

    localparam int NS = fnm_pkg::SQRT_CELLS;
    localparam int ND = fnm_pkg::DIV_CELLS;

    logic [1:0]       kind_reg;
    logic             adv;
    logic             out_valid_reg;
    fnm_pkg::out_t    out_data_reg;
    fnm_pkg::out_t    out_data_next;

    logic [NS:0]      sq_valid;
    fnm_pkg::fnm_sq_t sq_data [NS+1];
    logic [ND:0]      dv_valid;
    fnm_pkg::fnm_dv_t dv_data [ND+1];
    fnm_pkg::fnm_sq_t sq_last;
    fnm_pkg::fnm_dv_t dv_last;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= fnm_pkg::KIND_TRI_EDGE;
        end
        else if (cfg_we)
        begin
            kind_reg <= cfg_wdata;
        end
    end

    fnm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .kind      (kind_reg),
        .out_valid (sq_valid[0]),
        .out_data  (sq_data[0])
    );

    for (genvar i = 0; i < NS; i++)
    begin : g_sqrt
        fnm_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (sq_valid[i]),
            .in_data   (sq_data[i]),
            .out_valid (sq_valid[i+1]),
            .out_data  (sq_data[i+1])
        );
    end

    // Seed the divider with the edge length and scaled component magnitudes;
    // the surface measure is settled here for both modes.
    always_comb
    begin
        sq_last      = sq_data[NS];
        dv_data[0]   = '0;
        dv_data[0].meta = sq_last.meta;
        dv_data[0].d    = sq_last.root[fnm_pkg::DIV_W-1:0];
        dv_data[0].r0   = {3'b000, sq_last.meta.mag0, 15'd0};
        dv_data[0].r1   = {3'b000, sq_last.meta.mag1, 15'd0};
        if (sq_last.meta.is_face)
        begin
            dv_data[0].meta.surf = (sq_last.root[65:63] != 3'd0) ? {63{1'b1}}
                                                                  : sq_last.root[62:0];
        end
        else
        begin
            dv_data[0].meta.surf = {14'd0, sq_last.root[49:1]};
        end
    end
    assign dv_valid[0] = sq_valid[NS];

    for (genvar j = 0; j < ND; j++)
    begin : g_div
        fnm_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (dv_valid[j]),
            .in_data   (dv_data[j]),
            .out_valid (dv_valid[j+1]),
            .out_data  (dv_data[j+1])
        );
    end

    always_comb
    begin
        dv_last       = dv_data[ND];
        out_data_next = '0;
        out_data_next.status = dv_last.meta.status;
        if (dv_last.meta.status == fnm_pkg::STATUS_OK)
        begin
            out_data_next.surface_measure = dv_last.meta.surf;
            if (dv_last.meta.is_face)
            begin
                out_data_next.nx = dv_last.meta.fnx;
                out_data_next.ny = dv_last.meta.fny;
                out_data_next.nz = dv_last.meta.fnz;
            end
            else
            begin
                out_data_next.nx = dv_last.meta.neg0 ? 64'd0 - {31'd0, dv_last.q0}
                                                     : {31'd0, dv_last.q0};
                out_data_next.ny = dv_last.meta.neg1 ? 64'd0 - {31'd0, dv_last.q1}
                                                     : {31'd0, dv_last.q1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_valid[ND];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status != 2'd3)
        else $error("result item carries an undefined status code");

    a_fail_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != fnm_pkg::STATUS_OK |->
            out_data.nx == 64'd0 && out_data.ny == 64'd0 && out_data.nz == 64'd0
            && out_data.surface_measure == 63'd0)
        else $error("flagged item has nonzero normal or measure");

    a_bad_edge_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == fnm_pkg::STATUS_BAD_EDGE |->
            kind_reg == fnm_pkg::KIND_TRI_EDGE)
        else $error("invalid edge flagged outside triangle edge mode");

    a_ok_measure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == fnm_pkg::STATUS_OK |->
            out_data.surface_measure != 63'd0)
        else $error("nondegenerate item has zero measure");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("item taken while the pipeline is held");

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking bench for facet_normal_and_measure_unit: random and directed facets
// in all facet kinds, each result checked against a bit-exact normal predictor.
// Depends on fnm_pkg and the unit's RTL.
`timescale 1ns / 100ps

class normal_checker;
    logic [1:0]     kind;
    fnm_pkg::out_t  pending_normals[$];
    int             errors;
    int             checked;

    function new();
        kind = fnm_pkg::KIND_TRI_EDGE;
        errors = 0;
        checked = 0;
    endfunction

    static function logic [199:0] isqrt(logic [199:0] n);
        logic [199:0] acc;
        logic [199:0] t;
        acc = '0;
        for (int k = 99; k >= 0; k--)
        begin
            t = acc | (200'd1 << k);
            if (t * t <= n)
                acc = t;
        end
        return acc;
    endfunction

    // Unit component: |a| * 2^48 / len truncated toward zero, sign restored.
    static function logic [63:0] unit_part(longint a, logic [199:0] len);
        logic [199:0] m;
        logic [199:0] q;
        m = (a < 0) ? -a : a;
        q = (m << 48) / len;
        return (a < 0) ? -q[63:0] : q[63:0];
    endfunction

    static function logic [63:0] clamp64(logic signed [199:0] v);
        if (v > 200'sh7FFFFFFFFFFFFFFF)
            return 64'h7FFFFFFFFFFFFFFF;
        if (v < -200'sh8000000000000000)
            return 64'h8000000000000000;
        return v[63:0];
    endfunction

    function fnm_pkg::out_t normal_of(fnm_pkg::in_t d);
        fnm_pkg::out_t r;
        longint xs[4];
        longint ys[4];
        longint zs[3];
        int nodes;
        int a;
        int b;
        longint n0;
        longint n1;
        logic [199:0] m0;
        logic [199:0] m1;
        logic [199:0] len;
        logic signed [199:0] ux, uy, uz, vx, vy, vz;
        logic signed [199:0] c0, c1, c2;
        logic [199:0] a0, a1, a2;
        r = '0;
        xs = '{d.x0, d.x1, d.x2, d.x3};
        ys = '{d.y0, d.y1, d.y2, d.y3};
        zs = '{d.z0, d.z1, d.z2};
        if (kind == fnm_pkg::KIND_TRI_EDGE || kind == fnm_pkg::KIND_QUAD_EDGE)
        begin
            nodes = (kind == fnm_pkg::KIND_TRI_EDGE) ? 3 : 4;
            if (int'(d.edge_index) >= nodes)
            begin
                r.status = fnm_pkg::STATUS_BAD_EDGE;
                return r;
            end
            a = int'(d.edge_index);
            b = (a + 1) % nodes;
            n0 = ys[b] - ys[a];
            n1 = xs[a] - xs[b];
            if (n0 == 0 && n1 == 0)
            begin
                r.status = fnm_pkg::STATUS_DEGEN;
                return r;
            end
            m0 = (n0 < 0) ? -n0 : n0;
            m1 = (n1 < 0) ? -n1 : n1;
            len = isqrt((m0 * m0 + m1 * m1) << 32);
            r.nx = unit_part(n0, len);
            r.ny = unit_part(n1, len);
            r.surface_measure = len[63:1];
            r.status = fnm_pkg::STATUS_OK;
        end
        else
        begin
            // Facet kind 3 falls through to the face computation as well.
            ux = xs[0] - xs[1];
            uy = ys[0] - ys[1];
            uz = zs[0] - zs[1];
            vx = xs[0] - xs[2];
            vy = ys[0] - ys[2];
            vz = zs[0] - zs[2];
            c0 = uy * vz - vy * uz;
            c1 = vx * uz - ux * vz;
            c2 = ux * vy - vx * uy;
            a0 = (c0 < 0) ? -c0 : c0;
            a1 = (c1 < 0) ? -c1 : c1;
            a2 = (c2 < 0) ? -c2 : c2;
            len = isqrt(a0 * a0 + a1 * a1 + a2 * a2);
            if (len == 0)
            begin
                r.status = fnm_pkg::STATUS_DEGEN;
                return r;
            end
            r.nx = clamp64(c0);
            r.ny = clamp64(c1);
            r.nz = clamp64(c2);
            r.surface_measure = (len > 200'h7FFFFFFFFFFFFFFF) ? 63'h7FFFFFFFFFFFFFFF
                                                                : len[62:0];
            r.status = fnm_pkg::STATUS_OK;
        end
        return r;
    endfunction

    function void note_facet(fnm_pkg::in_t d);
        pending_normals.push_back(normal_of(d));
    endfunction

    function void check_result(fnm_pkg::out_t got);
        fnm_pkg::out_t want;
        if (pending_normals.size() == 0)
        begin
            $error("result item with nothing expected: %h", got);
            errors++;
            return;
        end
        want = pending_normals.pop_front();
        checked++;
        if (got.nx !== want.nx)
        begin
            $error("nx: expected %h, got %h", want.nx, got.nx);
            errors++;
        end
        if (got.ny !== want.ny)
        begin
            $error("ny: expected %h, got %h", want.ny, got.ny);
            errors++;
        end
        if (got.nz !== want.nz)
        begin
            $error("nz: expected %h, got %h", want.nz, got.nz);
            errors++;
        end
        if (got.surface_measure !== want.surface_measure)
        begin
            $error("surface_measure: expected %h, got %h",
                   want.surface_measure, got.surface_measure);
            errors++;
        end
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int LATENCY     = 106;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    fnm_pkg::in_t  in_data;
    logic out_valid;
    logic out_ready;
    fnm_pkg::out_t out_data;
    logic cfg_we;
    logic [1:0] cfg_wdata;

    normal_checker checker_h;
    int cycles;
    int burst_left;
    int stall_mode;
    int facets_sent;

    facet_normal_and_measure_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("facet_normal_and_measure_unit: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            checker_h.note_facet(in_data);
        if (rst_n && out_valid && out_ready)
            checker_h.check_result(out_data);
    end

    // Receiver stall pattern: the mode changes now and then.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    task automatic send_facet(fnm_pkg::in_t d);
        in_valid <= 1'b1;
        in_data <= d;
        do
            @(posedge clk);
        while (!in_ready);
        facets_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 30);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // Let the clock advance before polling so that an item taken at the last edge is already noted.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (checker_h.pending_normals.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_kind(logic [1:0] k);
        drain();
        repeat (LATENCY + 20) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= k;
        @(posedge clk);
        cfg_we <= 1'b0;
        checker_h.kind = k;
    endtask

    function automatic logic [31:0] coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h80000000;
            2: return 32'h7FFFFFFF;
            3: return $urandom_range(0, 1) ? 32'(-int'($urandom_range(0, 1000)))
                                           : 32'($urandom_range(0, 1000));
            default: return 32'($signed($urandom_range(0, 8388607)) - 4194304);
        endcase
    endfunction

    function automatic fnm_pkg::in_t random_facet();
        fnm_pkg::in_t d;
        d.edge_index = 2'($urandom_range(0, 3));
        d.x0 = coord();  d.x1 = coord();  d.x2 = coord();  d.x3 = coord();
        d.y0 = coord();  d.y1 = coord();  d.y2 = coord();  d.y3 = coord();
        d.z0 = coord();  d.z1 = coord();  d.z2 = coord();
        // Now and then collapse nodes or make them collinear to hit zero lengths.
        case ($urandom_range(0, 9))
            0:
            begin
                d.x1 = d.x0; d.y1 = d.y0; d.z1 = d.z0;
            end
            1:
            begin
                d.x2 = d.x1; d.y2 = d.y1; d.x3 = d.x2; d.y3 = d.y2;
            end
            2:
            begin
                d.x3 = d.x0; d.y3 = d.y0; d.z2 = d.z0; d.x2 = d.x0; d.y2 = d.y0;
            end
            3:
            begin
                d.x2 = d.x1; d.y2 = d.y1; d.z2 = d.z1;
            end
            default: ;
        endcase
        return d;
    endfunction

    task automatic directed_facets();
        fnm_pkg::in_t d;
        for (int e = 0; e < 4; e++)
        begin
            d = '0;
            d.edge_index = 2'(e);
            d.x1 = 32'h00010000;
            d.y2 = 32'h00010000;
            d.x3 = 32'h00010000;
            d.y3 = 32'h00010000;
            d.z2 = 32'h00020000;
            send_facet(d);
        end
        d = '0;
        send_facet(d);
        d = {2'd0, {11{32'h80000000}}};
        send_facet(d);
        d = '0;
        d.edge_index = 2'd1;
        d.x0 = 32'h80000000;  d.x1 = 32'h7FFFFFFF;  d.x2 = 32'h80000000;
        d.y0 = 32'h7FFFFFFF;  d.y1 = 32'h80000000;  d.y2 = 32'h7FFFFFFF;
        d.x3 = 32'h7FFFFFFF;  d.y3 = 32'h7FFFFFFF;
        d.z0 = 32'h80000000;  d.z1 = 32'h7FFFFFFF;  d.z2 = 32'h7FFFFFFF;
        send_facet(d);
        d.edge_index = 2'd2;
        d.y1 = 32'h7FFFFFFF;
        d.x2 = 32'h7FFFFFFF;
        send_facet(d);
        d.edge_index = 2'd3;
        send_facet(d);
        d = '1;
        send_facet(d);
    endtask

    initial
    begin
        logic [1:0] kinds[6];
        checker_h = new();
        cycles = 0;
        burst_left = 0;
        stall_mode = 0;
        facets_sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b1;
        cfg_we = 1'b0;
        cfg_wdata = fnm_pkg::KIND_TRI_EDGE;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first phase runs at the reset kind without a write.
        kinds = '{fnm_pkg::KIND_TRI_EDGE, fnm_pkg::KIND_QUAD_EDGE, fnm_pkg::KIND_TRI_FACE,
                  2'd3, fnm_pkg::KIND_QUAD_EDGE, fnm_pkg::KIND_TRI_EDGE};
        for (int p = 0; p < 6; p++)
        begin
            if (p > 0)
                set_kind(kinds[p]);
            if (p < 4)
                directed_facets();
            for (int i = 0; i < 180; i++)
            begin
                if (p == 2 && i == 90)
                    drain();
                send_facet(random_facet());
            end
        end

        drain();
        repeat (LATENCY + 20) @(posedge clk);
        $display("Sent %0d facets over all four kind settings, %0d results checked.",
                 facets_sent, checker_h.checked);
        if (checker_h.errors == 0 && checker_h.pending_normals.size() == 0)
            $display("facet_normal_and_measure_unit: match");
        else
            $display("facet_normal_and_measure_unit: mismatch");
        $finish;
    end
endmodule
